@@ rtl/core/skset_pkg.sv @@
// skset_pkg: shared types and constants for the sorted key set core.
// No dependencies; used by skset_cell, sorted_key_set_core and the testbench.
`default_nettype none

package skset_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int COUNT_OUT_W  = 5;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_DUP      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Broadcast to every cell in the row; the key travels on its own wire
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/skset_cell.sv @@
// skset_cell: one slot of the sorted row; compares its key with the broadcast
// key and shifts from its left or right neighbour. Depends on skset_pkg.
`default_nettype none

module skset_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic                              aclk,
    input  wire skset_pkg::cell_ctl_t              ctl,
    input  wire logic signed [skset_pkg::KEY_W-1:0] key_in,
    input  wire logic [CNT_W-1:0]                  count,
    input  wire logic                              lt_left,
    input  wire logic signed [skset_pkg::KEY_W-1:0] key_left,
    input  wire logic signed [skset_pkg::KEY_W-1:0] key_right,
    output logic                                   lt,
    output logic                                   eq,
    output logic signed [skset_pkg::KEY_W-1:0]     key_out
);

    logic signed [skset_pkg::KEY_W-1:0] key_reg;
    logic signed [skset_pkg::KEY_W-1:0] key_next;
    logic                               occ;

    assign occ     = (count > CNT_W'(IDX));
    assign lt      = occ && (key_reg < key_in);
    assign eq      = occ && (key_reg == key_in);
    assign key_out = key_reg;

    always_comb begin
        key_next = key_reg;
        if (ctl.ins_en && !lt) begin
            // first cell not below the new key takes it, the rest move up
            key_next = lt_left ? key_in : key_left;
        end else if (ctl.rem_en && !lt) begin
            key_next = key_right;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/sorted_key_set_core.sv @@
// sorted_key_set_core: top level of the sorted key set, a row of skset_cell.
// Depends on skset_pkg and skset_cell.
//
// Usage
//   Input channel (s_valid/s_ready, s_command, s_key): one beat per command,
//   insert (CMD_INSERT) or remove (CMD_REMOVE) of a signed 32-bit key.
//   Result channel (m_valid/m_ready, m_status, m_entry_count): exactly one
//   beat per command, in order: done, duplicate, not found or full, plus the
//   number of keys held once the command has taken effect.
//   Result: registered, shown in the cycle after the input beat is taken.
//   Throughput: one command per cycle while m_ready is high. Every cell
//   compares its key with the incoming key in the accept cycle; the leftmost
//   cell not below the key marks the insert or remove point, and the cells
//   from there up shift by one place at once. The critical path is one
//   32-bit compare per cell plus the match OR over CAPACITY cells.
//   Stall: a full result register holds while m_ready is low; s_ready is
//   then low, and it is high whenever the result register is empty or is
//   being drained in the same cycle.
//   Reset (aresetn low, synchronous): the set is emptied and no result is
//   pending. Key storage is not cleared; cells above the count are unused.
//   Duplicate wins over full; a remove from an empty set reports not found.
`default_nettype none

module sorted_key_set_core #(
    parameter int CAPACITY = skset_pkg::CAPACITY_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_command,
    input  wire logic signed [skset_pkg::KEY_W-1:0] s_key,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_status,
    output logic [skset_pkg::COUNT_OUT_W-1:0]       m_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                                   s_fire;
    logic                                   hit;
    logic                                   full;
    logic [CAPACITY-1:0]                    lt_vec;
    logic [CAPACITY-1:0]                    eq_vec;
    logic signed [skset_pkg::KEY_W-1:0]     key_q [CAPACITY];
    skset_pkg::cell_ctl_t                   ctl;
    skset_pkg::status_t                     status;

    logic [CNT_W-1:0]                       count_reg, count_next;
    logic                                   m_valid_reg, m_valid_next;
    skset_pkg::status_t                     m_status_reg;
    logic [skset_pkg::COUNT_OUT_W-1:0]      m_entry_count_reg;
    logic [CNT_W+skset_pkg::COUNT_OUT_W-1:0] count_ext;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign hit     = |eq_vec;
    assign full    = (count_reg >= CAP_CNT);

    // Decide the command from the compare results of the whole row
    always_comb begin
        ctl.ins_en = 1'b0;
        ctl.rem_en = 1'b0;
        count_next = count_reg;
        status     = skset_pkg::ST_DONE;
        if (s_command == skset_pkg::CMD_INSERT) begin
            if (hit) begin
                status = skset_pkg::ST_DUP;
            end else if (full) begin
                status = skset_pkg::ST_FULL;
            end else begin
                ctl.ins_en = s_fire;
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (!hit) begin
                status = skset_pkg::ST_NOTFOUND;
            end else begin
                ctl.rem_en = s_fire;
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // Row of cells; cell 0 sees "all to the left are below"
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                               lt_left;
        logic signed [skset_pkg::KEY_W-1:0] key_left;
        logic signed [skset_pkg::KEY_W-1:0] key_right;

        if (i == 0) begin : g_first
            assign lt_left  = 1'b1;
            assign key_left = key_q[i];
        end else begin : g_mid
            assign lt_left  = lt_vec[i-1];
            assign key_left = key_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign key_right = key_q[i];
        end else begin : g_notlast
            assign key_right = key_q[i+1];
        end

        skset_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .key_in    (s_key),
            .count     (count_reg),
            .lt_left   (lt_left),
            .key_left  (key_left),
            .key_right (key_right),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i]),
            .key_out   (key_q[i])
        );
    end

    assign m_valid_next = s_fire || (m_valid_reg && !m_ready);
    assign count_ext    = {{skset_pkg::COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, loaded only on an accepted beat
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_status_reg      <= status;
            m_entry_count_reg <= count_ext[skset_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_keys_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(eq_vec))
        else $error("key held in more than one cell");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.rem_en |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not shrink the count");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("accepted beat produced no result");
`endif

endmodule

`default_nettype wire

@@ tb/sv/sorted_key_set_checker.sv @@
// sorted_key_set_checker: watches both channels of sorted_key_set_core, keeps
// its own copy of the key set and compares every result beat in order.
// Depends on skset_pkg.

module sorted_key_set_checker #(
    parameter int CAPACITY = skset_pkg::CAPACITY_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic                                    s_command,
    input  logic signed [skset_pkg::KEY_W-1:0]      s_key,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [1:0]                              m_status,
    input  logic [skset_pkg::COUNT_OUT_W-1:0]       m_entry_count,
    output int                                      mismatches,
    output int                                      outstanding,
    output int                                      results_seen,
    output int                                      dup_seen,
    output int                                      miss_seen,
    output int                                      full_seen,
    output int                                      fill_peak
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        skset_pkg::status_t                  status;
        logic [skset_pkg::COUNT_OUT_W-1:0]   count;
    } outcome_t;

    // Shadow of the set: ascending keys in entries 0 .. set_size-1
    logic signed [skset_pkg::KEY_W-1:0] set_keys [CAPACITY];
    int                                 set_size;
    outcome_t                           pending_outcomes [$];

    int err_n, res_n, dup_n, miss_n, full_n, peak_n;

    assign mismatches   = err_n;
    assign results_seen = res_n;
    assign dup_seen     = dup_n;
    assign miss_seen    = miss_n;
    assign full_seen    = full_n;
    assign fill_peak    = peak_n;

    // Applies one command to the shadow set and returns the beat it must give
    function automatic outcome_t apply_command(
        input logic cmd, input logic signed [skset_pkg::KEY_W-1:0] k);
        int       pos;
        int       i;
        logic     hit;
        outcome_t r;
        pos = 0;
        while (pos < set_size && set_keys[pos] < k)
            pos++;
        hit = (pos < set_size) && (set_keys[pos] == k);
        if (cmd == skset_pkg::CMD_INSERT) begin
            if (hit) begin
                r.status = skset_pkg::ST_DUP;
            end else if (set_size >= CAPACITY) begin
                r.status = skset_pkg::ST_FULL;
            end else begin
                for (i = set_size; i > pos; i--)
                    set_keys[i] = set_keys[i-1];
                set_keys[pos] = k;
                set_size++;
                r.status = skset_pkg::ST_DONE;
            end
        end else begin
            if (!hit) begin
                r.status = skset_pkg::ST_NOTFOUND;
            end else begin
                for (i = pos; i + 1 < set_size; i++)
                    set_keys[i] = set_keys[i+1];
                set_size--;
                r.status = skset_pkg::ST_DONE;
            end
        end
        r.count = skset_pkg::COUNT_OUT_W'(set_size);
        return r;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            set_size = 0;
            pending_outcomes.delete();
            err_n  = 0;
            res_n  = 0;
            dup_n  = 0;
            miss_n = 0;
            full_n = 0;
            peak_n = 0;
        end else begin
            // result side first: a beat taken now belongs to an earlier command
            if (m_valid && m_ready) begin
                res_n++;
                case (skset_pkg::status_t'(m_status))
                    skset_pkg::ST_DUP:      dup_n++;
                    skset_pkg::ST_NOTFOUND: miss_n++;
                    skset_pkg::ST_FULL:     full_n++;
                    default:                ;
                endcase
                if (pending_outcomes.size() == 0) begin
                    err_n++;
                    $display("%0t: unexpected result beat, status %0d count %0d",
                             $time, m_status, m_entry_count);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_status !== want.status) begin
                        err_n++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_status);
                    end
                    if (m_entry_count !== want.count) begin
                        err_n++;
                        $display("%0t: entry count expected %0d, got %0d",
                                 $time, want.count, m_entry_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_outcomes.push_back(apply_command(s_command, s_key));
                if (set_size > peak_n)
                    peak_n = set_size;
            end
        end
        outstanding <= pending_outcomes.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: stimulus and verdict for sorted_key_set_core.
// Depends on skset_pkg, sorted_key_set_core and sorted_key_set_checker.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RAND_CMDS  = 750;
    localparam int          POOL_N     = 24;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam int          HOLD_LEN   = 80;       // long receiver hold-off
    localparam logic        INS        = skset_pkg::CMD_INSERT;
    localparam logic        REM        = skset_pkg::CMD_REMOVE;

    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    logic                               s_command = skset_pkg::CMD_INSERT;
    logic signed [skset_pkg::KEY_W-1:0] s_key     = '0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    logic [1:0]                         m_status;
    logic [skset_pkg::COUNT_OUT_W-1:0]  m_entry_count;

    int          mismatches, outstanding, results_seen;
    int          dup_seen, miss_seen, full_seen, fill_peak;
    int unsigned cycle_cnt = 0;
    int          cmds_sent = 0;
    bit          hold_done = 1'b0;

    sorted_key_set_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    sorted_key_set_checker u_set_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .dup_seen      (dup_seen),
        .miss_seen     (miss_seen),
        .full_seen     (full_seen),
        .fill_peak     (fill_peak)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one command beat and returns at the edge where it is taken.
    // Valid is left high so a following beat goes out back to back; the
    // caller drops it only when a gap follows.
    task automatic send_beat(input logic cmd,
                             input logic signed [skset_pkg::KEY_W-1:0] k);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= k;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        cmds_sent++;
    endtask

    // Receiver: segments of different stall patterns. Once the random phase
    // is under way it holds off for a long stretch so the result register
    // fills and s_ready drops while the sender keeps offering.
    initial begin
        int mode;
        int seg;
        forever begin
            if (!hold_done && cycle_cnt > 300) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 9);
                seg  = $urandom_range(8, 60);
                repeat (seg) begin
                    case (mode)
                        0, 1, 2, 3: m_ready <= 1'b1;                         // no stalls
                        4, 5, 6:    m_ready <= ($urandom_range(0, 1) == 1);
                        7, 8:       m_ready <= ($urandom_range(0, 3) == 0);  // heavy stall
                        default:    m_ready <= ~m_ready;                     // alternating
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic signed [skset_pkg::KEY_W-1:0] key_pool [POOL_N];
        logic signed [skset_pkg::KEY_W-1:0] edge_keys [6];
        logic signed [skset_pkg::KEY_W-1:0] k;
        logic                               cmd;
        int                                 ins_pct;
        int                                 burst;
        int                                 gap;
        int                                 pick;
        int                                 n;

        edge_keys = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh00000000,
                      32'shFFFFFFFF, 32'sh80000001, 32'sh7FFFFFFE};

        // synchronous reset at the start, the only one in the run
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, back to back ----
        send_beat(REM, 32'sd5);                 // remove from empty set
        send_beat(INS, 32'sh80000000);          // most negative key
        send_beat(INS, 32'sh7FFFFFFF);          // most positive key
        send_beat(INS, 32'sd0);
        send_beat(INS, -32'sd1);
        send_beat(INS, 32'sd1);
        send_beat(INS, 32'sd0);                 // duplicate
        send_beat(REM, 32'sd5);                 // absent key
        // fill up to capacity with keys that land between the two extreme keys
        send_beat(INS, 32'sd100);
        send_beat(INS, -32'sd100);
        send_beat(INS, 32'sd2);
        send_beat(INS, -32'sd2);
        send_beat(INS, 32'sd1000);
        send_beat(INS, -32'sd1000);
        send_beat(INS, 32'sd3);
        send_beat(INS, 32'sh40000000);
        send_beat(INS, 32'shC0000000);
        send_beat(INS, 32'sd7);
        send_beat(INS, -32'sd7);
        send_beat(INS, 32'sd42);                // refused, set is full
        send_beat(INS, 32'sd0);                 // duplicate wins over full
        send_beat(REM, 32'sh7FFFFFFF);          // top entry
        send_beat(REM, 32'sh80000000);          // bottom entry
        send_beat(REM, 32'sd0);                 // middle entry

        // ---- random part ----
        // Keys mostly come from a small pool so inserts and removes keep
        // hitting held keys; the pool is larger than the capacity so the
        // set also runs full. Insert bias changes per phase to sweep the
        // fill level between empty and full.
        n       = 0;
        ins_pct = 50;
        while (n < RAND_CMDS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if (n % 150 == 0) begin
                    foreach (key_pool[i])
                        key_pool[i] = (i < POOL_N / 2) ? $urandom_range(0, 40) - 20
                                                        : $urandom;
                end
                if (n % 60 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       ins_pct = 85;
                        1:       ins_pct = 50;
                        default: ins_pct = 15;
                    endcase
                end
                cmd  = ($urandom_range(0, 99) < ins_pct) ? INS : REM;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    k = key_pool[$urandom_range(0, POOL_N - 1)];
                else if (pick < 90)
                    k = $urandom;
                else
                    k = edge_keys[$urandom_range(0, 5)];
                send_beat(cmd, k);
                n++;
            end
            // a quarter of bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        // drain: wait for every result beat, then a few quiet cycles
        do
            @(posedge aclk);
        while (outstanding != 0);
        repeat (4) @(posedge aclk);

        $display("Sent %0d commands, checked %0d results: %0d duplicate, %0d not found, %0d full.",
                 cmds_sent, results_seen, dup_seen, miss_seen, full_seen);
        $display("Set filled to %0d keys at peak; long receiver hold-off %0s.",
                 fill_peak, hold_done ? "applied" : "not reached");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sorted_key_set_core.f @@
rtl/core/skset_pkg.sv
rtl/core/skset_cell.sv
rtl/core/sorted_key_set_core.sv
tb/sv/sorted_key_set_checker.sv
tb/sv/tb_top.sv
